### rtl/fud_pkg.sv
// Shared types, character constants and hex helpers for the form-urlencoded decoder.
package fud_pkg;

    // Characters with a special meaning in the encoding.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;

    // Escape progress: nothing held, percent sign held, percent sign and one digit held.
    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // Everything one input byte produces: up to three bytes and the new escape state.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        phase_t     phase;
        logic [7:0] held;
    } fud_dec_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Digits carry their value in the low nibble; letters of either case are offset by nine.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if ((c >= CH_0) && (c <= CH_9)) begin
            v = c[3:0];
        end else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF))) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = 4'd0;
        end
        return v;
    endfunction

endpackage

### rtl/fud_decode.sv
// Combinational decode of one byte against the held escape state.
module fud_decode
    import fud_pkg::*;
(
    input  phase_t     phase_i,
    input  logic [7:0] held_i,
    input  logic [7:0] byte_i,
    input  logic       end_i,
    output fud_dec_t   dec_o
);

    logic       f_pct;
    logic       f_emit;
    logic [7:0] f_byte;
    phase_t     f_phase;
    logic       cur_hex;

    // Handling of a byte with no escape pending.
    always_comb begin
        f_pct   = (byte_i == CH_PERCENT);
        f_emit  = !f_pct || end_i;
        f_byte  = f_pct ? CH_PERCENT : ((byte_i == CH_PLUS) ? CH_SPACE : byte_i);
        f_phase = (f_pct && !end_i) ? PH_PCT : PH_NONE;
        cur_hex = is_hex(byte_i);
    end

    // Combine the held escape with the current byte.
    always_comb begin
        dec_o.cnt   = {1'b0, f_emit};
        dec_o.b0    = f_byte;
        dec_o.b1    = f_byte;
        dec_o.b2    = f_byte;
        dec_o.phase = f_phase;
        dec_o.held  = held_i;
        case (phase_i)
            PH_PCT: begin
                dec_o.b0 = CH_PERCENT;
                if (cur_hex && end_i) begin
                    dec_o.cnt   = 2'd2;
                    dec_o.b1    = byte_i;
                    dec_o.phase = PH_NONE;
                end else if (cur_hex) begin
                    dec_o.cnt   = 2'd0;
                    dec_o.held  = byte_i;
                    dec_o.phase = PH_DIGIT;
                end else begin
                    dec_o.cnt = 2'd1 + {1'b0, f_emit};
                end
            end
            PH_DIGIT: begin
                if (cur_hex) begin
                    dec_o.cnt   = 2'd1;
                    dec_o.b0    = {hex_value(held_i), hex_value(byte_i)};
                    dec_o.phase = PH_NONE;
                end else begin
                    dec_o.cnt = 2'd2 + {1'b0, f_emit};
                    dec_o.b0  = CH_PERCENT;
                    dec_o.b1  = held_i;
                end
            end
            default: begin
                dec_o.cnt = {1'b0, f_emit};
            end
        endcase
    end

endmodule

### rtl/form_urlencoded_decoder_unit.sv
// Top level of the form-urlencoded decoder: input register, decode and result buffer.
// Decodes a form-urlencoded token one byte per beat: '+' becomes a space, '%' with two hex
// digits becomes the encoded byte, and a broken escape passes through verbatim. A beat with
// s_token_end set flushes any held escape bytes. Each input beat gives zero to three result
// beats; m_run_last marks the last of each run and m_token_last the last of a token. Bytes
// pass an input register and a three-entry result buffer before they appear as results. The
// block takes one input beat per cycle as long as each byte yields at most one result and
// m_ready is high; a byte that yields two or three results holds the input until its run is
// down to its last beat, as the result buffer sends one beat per cycle while m_ready is high.
module form_urlencoded_decoder_unit
    import fud_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_token_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_token_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    phase_t     phase_reg;
    logic [7:0] held_reg;
    logic [1:0] run_cnt_reg;
    logic [7:0] run_b0_reg;
    logic [7:0] run_b1_reg;
    logic [7:0] run_b2_reg;
    logic       run_end_reg;

    fud_dec_t   dec;
    logic       decode_take;
    logic       m_beat;

    fud_decode u_decode (
        .phase_i (phase_reg),
        .held_i  (held_reg),
        .byte_i  (in_byte_reg),
        .end_i   (in_end_reg),
        .dec_o   (dec)
    );

    // The buffered byte moves on once the result buffer is empty or sends its last beat now.
    assign m_beat      = m_valid && m_ready;
    assign decode_take = in_valid_reg &&
                         ((run_cnt_reg == 2'd0) || ((run_cnt_reg == 2'd1) && m_ready));
    assign s_ready     = !in_valid_reg || decode_take;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_token_end;
        end
    end

    // Escape state advances with each decoded byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NONE;
            held_reg  <= 8'd0;
        end else if (decode_take) begin
            phase_reg <= dec.phase;
            held_reg  <= dec.held;
        end
    end

    // Result buffer: loaded with a whole run, then shifted out one beat at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg <= 2'd0;
        end else if (decode_take) begin
            run_cnt_reg <= dec.cnt;
        end else if (m_beat) begin
            run_cnt_reg <= run_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (decode_take) begin
            run_b0_reg  <= dec.b0;
            run_b1_reg  <= dec.b1;
            run_b2_reg  <= dec.b2;
            run_end_reg <= in_end_reg;
        end else if (m_beat) begin
            run_b0_reg <= run_b1_reg;
            run_b1_reg <= run_b2_reg;
        end
    end

    assign m_valid      = (run_cnt_reg != 2'd0);
    assign m_out_byte   = run_b0_reg;
    assign m_run_last   = (run_cnt_reg == 2'd1);
    assign m_token_last = (run_cnt_reg == 2'd1) && run_end_reg;

    // A run of two or more results blocks the next decode.
    a_multi_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_cnt_reg > 2'd1) |-> !decode_take)
        else $error("decode taken while a multi-beat run is pending");

    // A byte that ends a token leaves no escape held.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (decode_take && in_end_reg) |=> (phase_reg == PH_NONE))
        else $error("escape still held after token end");

    // A token end always produces at least one result.
    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (decode_take && in_end_reg) |=> (m_valid && run_end_reg))
        else $error("token end gave no result");

    // A buffered byte that is not taken stays put.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !decode_take) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register changed while waiting");

    // Without a new decode, a sent beat shortens the run by one.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && !decode_take) |=> (run_cnt_reg == $past(run_cnt_reg) - 2'd1))
        else $error("result buffer count out of step");

endmodule

### verif/form_urlencoded_decoder_unit_test.sv
// Self-checking testbench for the form-urlencoded decoder: directed tokens, then random ones.
import fud_pkg::*;

// Tracks the escape state of the decoder and the decoded bytes still owed by it.
class url_decode_tracker;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       tok_end;
    } beat_t;

    fud_pkg::phase_t esc_phase;
    logic [7:0]      held_char;
    logic [7:0]      run_bytes[$];
    beat_t           awaited[$];
    int              mismatches;
    int              results_seen;

    function new();
        esc_phase    = fud_pkg::PH_NONE;
        held_char    = 8'h00;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function bit is_digit_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // Only called on characters already known to be hex digits.
    function logic [3:0] digit_value(logic [7:0] c);
        if (c <= fud_pkg::CH_9) return 4'(c - fud_pkg::CH_0);
        if (c >= fud_pkg::CH_LA) return 4'(c - fud_pkg::CH_LA + 8'd10);
        return 4'(c - fud_pkg::CH_UA + 8'd10);
    endfunction

    // Appends one decoded byte to the run of the current input beat.
    function void queue_byte(logic [7:0] b);
        run_bytes.insert(run_bytes.size(), b);
    endfunction

    // A byte seen with no escape open: a percent sign opens one unless the token ends here.
    function void take_fresh(logic [7:0] b, logic fin);
        if (b == fud_pkg::CH_PERCENT && !fin) begin
            esc_phase = fud_pkg::PH_PCT;
        end else begin
            queue_byte(b == fud_pkg::CH_PLUS ? fud_pkg::CH_SPACE : b);
            esc_phase = fud_pkg::PH_NONE;
        end
    endfunction

    // Works out the result beats that one accepted input beat causes.
    function void note_input(logic [7:0] b, logic fin);
        beat_t e;
        run_bytes.delete();
        case (esc_phase)
            fud_pkg::PH_PCT: begin
                if (is_digit_char(b)) begin
                    if (fin) begin
                        queue_byte(fud_pkg::CH_PERCENT);
                        queue_byte(b);
                        esc_phase = fud_pkg::PH_NONE;
                    end else begin
                        held_char = b;
                        esc_phase = fud_pkg::PH_DIGIT;
                    end
                end else begin
                    queue_byte(fud_pkg::CH_PERCENT);
                    take_fresh(b, fin);
                end
            end
            fud_pkg::PH_DIGIT: begin
                if (is_digit_char(b)) begin
                    queue_byte({digit_value(held_char), digit_value(b)});
                    esc_phase = fud_pkg::PH_NONE;
                end else begin
                    queue_byte(fud_pkg::CH_PERCENT);
                    queue_byte(held_char);
                    take_fresh(b, fin);
                end
            end
            default: take_fresh(b, fin);
        endcase
        foreach (run_bytes[k]) begin
            e.data    = run_bytes[k];
            e.run_end = (k == run_bytes.size() - 1);
            e.tok_end = e.run_end && fin;
            awaited.insert(awaited.size(), e);
        end
    endfunction

    // Compares one result beat with the oldest outstanding byte.
    function void check_result(logic [7:0] data, logic run_end, logic tok_end);
        beat_t want;
        results_seen++;
        if (awaited.size() == 0) begin
            if (mismatches < 10)
                $display("ERROR: unexpected result beat byte=%h run_last=%b token_last=%b",
                         data, run_end, tok_end);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        if (want.data !== data || want.run_end !== run_end || want.tok_end !== tok_end) begin
            if (mismatches < 10)
                $display({"ERROR: result %0d expected byte=%h run_last=%b token_last=%b,",
                          " got byte=%h run_last=%b token_last=%b"},
                         results_seen, want.data, want.run_end, want.tok_end,
                         data, run_end, tok_end);
            mismatches++;
        end
    endfunction

endclass

module form_urlencoded_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int BEATS_PER_PHASE = 75;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_token_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;
    logic       m_token_last;

    url_decode_tracker decoded = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  beats_sent = 0;
    int  tokens_sent = 0;
    int  quiet_cycles = 0;
    string hex_chars = "0123456789abcdefABCDEF";

    form_urlencoded_decoder_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_token_end  (s_token_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_token_last (m_token_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one byte, idling first at the current rate, and waits until it is taken.
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_token_end <= fin;
        do @(posedge aclk); while (!s_ready);
        decoded.note_input(b, fin);
        beats_sent++;
    endtask

    task automatic send_text(input string txt, input bit ends_token);
        for (int k = 0; k < txt.len(); k++)
            send_beat(txt[k], ends_token && (k == txt.len() - 1));
        if (ends_token) tokens_sent++;
    endtask

    function automatic logic [7:0] pick_hex();
        return hex_chars[$urandom_range(hex_chars.len() - 1)];
    endfunction

    // Mostly well-formed tokens with random content, mixed with stray and broken escapes.
    task automatic send_random_token();
        logic [7:0] seq[$];
        int len;
        int pick;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                seq.insert(seq.size(), 8'($urandom_range(255)));
            end else if (pick < 50) begin
                seq.insert(seq.size(), CH_PLUS);
            end else if (pick < 85) begin
                seq.insert(seq.size(), CH_PERCENT);
                seq.insert(seq.size(), pick_hex());
                seq.insert(seq.size(), pick_hex());
            end else if (pick < 93) begin
                seq.insert(seq.size(), CH_PERCENT);
                seq.insert(seq.size(), pick_hex());
            end else begin
                seq.insert(seq.size(), CH_PERCENT);
            end
        end
        foreach (seq[k]) send_beat(seq[k], k == seq.size() - 1);
        tokens_sent++;
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check every result beat as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            decoded.check_result(m_out_byte, m_run_last, m_token_last);
    end

    // Watchdog: too long without any beat moving on either side ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d cycles without progress", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: plus sign, escape completed at token end, both letter cases,
        // a percent sign reopening an escape, incomplete escapes at token end,
        // non-hex neighbors of the digit ranges, and the byte extremes.
        send_text("+%41", 1'b1);
        send_text("%fF", 1'b0);
        send_text("%G%4", 1'b1);
        send_text("%%41", 1'b0);
        send_text("%%", 1'b1);
        send_text("%4+", 1'b1);
        send_text("%/:", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        tokens_sent++;

        // Random tokens over four idling phases; the first one starts with a long hold-off.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 0) hold_request = 1'b1;
            while (beats_sent < 25 + (ph + 1) * BEATS_PER_PHASE) send_random_token();
        end
        s_valid <= 1'b0;

        // Drain the outstanding results, then give the block a few cycles to misbehave.
        while (decoded.awaited.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d tokens in %0d input beats and checked %0d result beats,",
                 tokens_sent, beats_sent, decoded.results_seen);
        $display("with four idling phases and one long result hold-off; %0d mismatches.",
                 decoded.mismatches);
        if (decoded.mismatches == 0 && decoded.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fud_pkg.sv
rtl/fud_decode.sv
rtl/form_urlencoded_decoder_unit.sv
verif/form_urlencoded_decoder_unit_test.sv
